// ===== src/pcmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmq_pkg
// Shared types and codes for the pcm frame packer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcmq_pkg;

    // request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_POP   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // frame length after reset
    localparam logic [11:0] FRAME_LENGTH_RESET = 12'd1600;

    // command field widths, sized for the largest supported configuration
    localparam int CMD_ADDR_W = 23;
    localparam int CMD_SLOT_W = 11;
    localparam int CMD_CNT_W  = 13;

    // depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    // input item
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] sample;
        logic               silent;
        logic [11:0]        read_index;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic               frame_committed;
        logic [11:0]        front_length;
        logic signed [15:0] read_sample;
        logic [7:0]         queue_level;
        logic [11:0]        fill_level;
    } rsp_item_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]            status;
        logic                  committed;
        logic [CMD_SLOT_W-1:0] level;
        logic [CMD_CNT_W-1:0]  fill;
        logic                  samp_we;
        logic [CMD_ADDR_W-1:0] samp_addr;
        logic [15:0]           samp_data;
        logic                  len_we;
        logic [CMD_SLOT_W-1:0] len_slot;
        logic [CMD_CNT_W-1:0]  len_data;
        logic                  is_read;
        logic [CMD_ADDR_W-1:0] rd_addr;
        logic [11:0]           rd_idx;
        logic                  rd_in_range;
        logic [CMD_SLOT_W-1:0] front_slot;
        logic                  front_valid;
    } cmd_t;

endpackage

// ===== src/pcmq_front.sv =====
// ----------------------------------------------------------------------------
// pcmq_front
// Accepts requests, keeps fill, level, pointers and overflow state, and turns
// each request into one command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmq_front #(
    parameter int SLOTS        = 128,
    parameter int SLOT_SAMPLES = 2400
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [11:0]         cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  pcmq_pkg::req_item_t req_item,
    output logic                cmd_push,
    output pcmq_pkg::cmd_t      cmd,
    input  logic                cmd_full
);

    // one spare physical slot holds the frame under assembly
    localparam int SLOT_W    = $clog2(SLOTS + 1);
    localparam int LVL_W     = $clog2(SLOTS + 1);
    localparam int CNT_W     = $clog2(SLOT_SAMPLES + 1);
    localparam int ADDR_W    = $clog2((SLOTS + 1) * SLOT_SAMPLES);
    localparam int LAST_BASE = SLOTS * SLOT_SAMPLES;

    logic [11:0]       flen_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              ovf_reg, ovf_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [ADDR_W-1:0] wr_base_reg, wr_base_next;
    logic [ADDR_W-1:0] rd_base_reg, rd_base_next;

    logic              accept;
    logic [CNT_W-1:0]  target;
    logic [CNT_W-1:0]  fill_inc;
    logic [CNT_W-1:0]  commit_len;
    logic              commit_req;
    logic              ring_full;

    assign req_ready = !cmd_full;
    assign accept    = req_valid && req_ready;
    assign cmd_push  = accept;

    // frame length clamped to 1..SLOT_SAMPLES
    always_comb
    begin
        if (flen_reg == 12'd0)
        begin
            target = CNT_W'(1);
        end
        else if ({1'b0, flen_reg} > 13'(SLOT_SAMPLES))
        begin
            target = CNT_W'(SLOT_SAMPLES);
        end
        else
        begin
            target = CNT_W'(flen_reg);
        end
    end

    assign fill_inc  = (fill_reg < CNT_W'(SLOT_SAMPLES)) ? fill_reg + CNT_W'(1) : fill_reg;
    assign ring_full = (level_reg == LVL_W'(SLOTS));

    // request classification and next state
    always_comb
    begin
        fill_next    = fill_reg;
        level_next   = level_reg;
        ovf_next     = ovf_reg;
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        wr_base_next = wr_base_reg;
        rd_base_next = rd_base_reg;
        commit_req   = 1'b0;
        commit_len   = fill_reg;
        cmd          = '0;
        cmd.status   = pcmq_pkg::ST_OK;

        unique case (req_item.req_type) inside
            pcmq_pkg::REQ_PUSH, pcmq_pkg::REQ_FLUSH:
            begin
                if (ovf_reg)
                begin
                    cmd.status = pcmq_pkg::ST_OVERFLOW;
                end
                else if (req_item.req_type == pcmq_pkg::REQ_PUSH)
                begin
                    if (fill_reg < CNT_W'(SLOT_SAMPLES))
                    begin
                        cmd.samp_we   = 1'b1;
                        cmd.samp_addr = pcmq_pkg::CMD_ADDR_W'(wr_base_reg
                                        + ADDR_W'(fill_reg));
                        cmd.samp_data = req_item.silent ? 16'd0 : req_item.sample;
                    end
                    fill_next = fill_inc;
                    if (fill_inc >= target)
                    begin
                        commit_req = 1'b1;
                        commit_len = fill_inc;
                    end
                end
                else if (fill_reg != '0)
                begin
                    commit_req = 1'b1;
                    commit_len = fill_reg;
                end
            end
            pcmq_pkg::REQ_READ, pcmq_pkg::REQ_POP:
            begin
                if (level_reg == '0)
                begin
                    cmd.status = pcmq_pkg::ST_EMPTY;
                end
                else if (req_item.req_type == pcmq_pkg::REQ_READ)
                begin
                    cmd.is_read     = 1'b1;
                    cmd.rd_idx      = req_item.read_index;
                    cmd.rd_in_range = ({1'b0, req_item.read_index} < 13'(SLOT_SAMPLES));
                    cmd.rd_addr     = cmd.rd_in_range
                                      ? pcmq_pkg::CMD_ADDR_W'(rd_base_reg
                                        + ADDR_W'(req_item.read_index))
                                      : pcmq_pkg::CMD_ADDR_W'(rd_base_reg);
                end
                else
                begin
                    level_next   = level_reg - LVL_W'(1);
                    rd_slot_next = (rd_slot_reg == SLOT_W'(SLOTS))
                                   ? '0 : rd_slot_reg + SLOT_W'(1);
                    rd_base_next = (rd_base_reg == ADDR_W'(LAST_BASE))
                                   ? '0 : rd_base_reg + ADDR_W'(SLOT_SAMPLES);
                end
            end
            default:
            begin
                cmd.status = pcmq_pkg::ST_OK;
            end
        endcase

        // commit of the assembled frame
        if (commit_req)
        begin
            fill_next = '0;
            if (ring_full)
            begin
                ovf_next   = 1'b1;
                cmd.status = pcmq_pkg::ST_OVERFLOW;
            end
            else
            begin
                cmd.committed = 1'b1;
                cmd.len_we    = 1'b1;
                cmd.len_slot  = pcmq_pkg::CMD_SLOT_W'(wr_slot_reg);
                cmd.len_data  = pcmq_pkg::CMD_CNT_W'(commit_len);
                level_next    = level_reg + LVL_W'(1);
                wr_slot_next  = (wr_slot_reg == SLOT_W'(SLOTS))
                                ? '0 : wr_slot_reg + SLOT_W'(1);
                wr_base_next  = (wr_base_reg == ADDR_W'(LAST_BASE))
                                ? '0 : wr_base_reg + ADDR_W'(SLOT_SAMPLES);
            end
        end

        cmd.level       = pcmq_pkg::CMD_SLOT_W'(level_next);
        cmd.fill        = pcmq_pkg::CMD_CNT_W'(fill_next);
        cmd.front_slot  = pcmq_pkg::CMD_SLOT_W'(rd_slot_next);
        cmd.front_valid = (level_next != '0);
    end

    // frame length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg <= pcmq_pkg::FRAME_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            flen_reg <= cfg_data;
        end
    end

    // counters and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            level_reg   <= '0;
            ovf_reg     <= 1'b0;
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            wr_base_reg <= '0;
            rd_base_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg    <= fill_next;
            level_reg   <= level_next;
            ovf_reg     <= ovf_next;
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            wr_base_reg <= wr_base_next;
            rd_base_reg <= rd_base_next;
        end
    end

endmodule

// ===== src/pcmq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pcmq_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmq_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcmq_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output pcmq_pkg::cmd_t pop_data,
    output logic           not_empty
);

    localparam int CNT_W = pcmq_pkg::CMDQ_PTR_W + 1;

    pcmq_pkg::cmd_t                    entry_reg [pcmq_pkg::CMDQ_DEPTH];
    logic [pcmq_pkg::CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [pcmq_pkg::CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]                  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(pcmq_pkg::CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/pcmq_back.sv =====
// ----------------------------------------------------------------------------
// pcmq_back
// Executes commands against the sample and length memories in order and
// builds the result items in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmq_back #(
    parameter int SLOTS        = 128,
    parameter int SLOT_SAMPLES = 2400
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  pcmq_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pcmq_pkg::rsp_item_t rsp_item
);

    localparam int SLOT_W = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOT_SAMPLES + 1);
    localparam int ADDR_W = $clog2((SLOTS + 1) * SLOT_SAMPLES);
    localparam int DEPTH  = (SLOTS + 1) * SLOT_SAMPLES;

    // memories: one sample row and one length per physical slot
    logic [15:0]      samp_mem [DEPTH];
    logic [CNT_W-1:0] len_mem  [SLOTS + 1];

    logic [15:0]      samp_q_reg;
    logic [CNT_W-1:0] len_q_reg;

    // command in flight while the memories answer
    logic                            p1_valid_reg;
    logic [1:0]                      p1_status_reg;
    logic                            p1_committed_reg;
    logic [pcmq_pkg::CMD_SLOT_W-1:0] p1_level_reg;
    logic [pcmq_pkg::CMD_CNT_W-1:0]  p1_fill_reg;
    logic                            p1_is_read_reg;
    logic [11:0]                     p1_rd_idx_reg;
    logic                            p1_in_range_reg;
    logic                            p1_front_valid_reg;

    logic                rsp_valid_reg;
    pcmq_pkg::rsp_item_t rsp_item_reg, rsp_item_next;

    logic out_free;
    logic issue;
    logic idx_ok;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign issue     = cmd_valid && (!p1_valid_reg || out_free);
    assign cmd_pop   = issue;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // sample memory
    always_ff @(posedge clk)
    begin
        if (issue && cmd.samp_we)
        begin
            samp_mem[cmd.samp_addr[ADDR_W-1:0]] <= cmd.samp_data;
        end
        if (issue && cmd.is_read)
        begin
            samp_q_reg <= samp_mem[cmd.rd_addr[ADDR_W-1:0]];
        end
    end

    // length memory, read of the front slot sees a same-cycle commit
    always_ff @(posedge clk)
    begin
        if (issue && cmd.len_we)
        begin
            len_mem[cmd.len_slot[SLOT_W-1:0]] <= cmd.len_data[CNT_W-1:0];
        end
        if (issue)
        begin
            if (cmd.len_we && (cmd.len_slot == cmd.front_slot))
            begin
                len_q_reg <= cmd.len_data[CNT_W-1:0];
            end
            else
            begin
                len_q_reg <= len_mem[cmd.front_slot[SLOT_W-1:0]];
            end
        end
    end

    // in-flight stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_status_reg      <= cmd.status;
            p1_committed_reg   <= cmd.committed;
            p1_level_reg       <= cmd.level;
            p1_fill_reg        <= cmd.fill;
            p1_is_read_reg     <= cmd.is_read;
            p1_rd_idx_reg      <= cmd.rd_idx;
            p1_in_range_reg    <= cmd.rd_in_range;
            p1_front_valid_reg <= cmd.front_valid;
        end
    end

    // result assembly
    assign idx_ok = p1_in_range_reg
                    && ({1'b0, p1_rd_idx_reg} < pcmq_pkg::CMD_CNT_W'(len_q_reg));

    always_comb
    begin
        rsp_item_next                 = '0;
        rsp_item_next.status          = p1_status_reg;
        rsp_item_next.frame_committed = p1_committed_reg;
        rsp_item_next.front_length    = p1_front_valid_reg ? 12'(len_q_reg) : 12'd0;
        rsp_item_next.queue_level     = p1_level_reg[7:0];
        rsp_item_next.fill_level      = p1_fill_reg[11:0];
        if (p1_is_read_reg)
        begin
            if (idx_ok)
            begin
                rsp_item_next.read_sample = samp_q_reg;
            end
            else
            begin
                rsp_item_next.status = pcmq_pkg::ST_RANGE;
            end
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && p1_valid_reg)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                rsp_valid_reg <= p1_valid_reg;
            end
        end
    end

endmodule

// ===== src/pcm_frame_packer_queue.sv =====
// ----------------------------------------------------------------------------
// pcm_frame_packer_queue
// Packs PCM16 samples into frames of frame_length samples and queues finished
// frames, at most SLOTS, in a ring for a consumer that reads and pops them.
//
// Requests arrive on req_valid/req_ready/req_item: push a sample, flush a
// partial frame, read a sample of the front frame, or pop the front frame.
// Every request gives exactly one result on rsp_valid/rsp_ready/rsp_item,
// in request order. frame_length is written through cfg_we/cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Throughput is one transfer per cycle in each direction while the receiver
// does not stall. A result passes through the command queue, the registered
// read of the sample and length memories and the output register.
// Reset clears counters, pointers and the overflow flag and loads a frame
// length of 1600; the memories are not cleared, as no unwritten entry is
// ever returned. When the receiver stalls, up to six requests are held (four in
// the command queue, one in flight, one in the output register), then
// req_ready drops until a result transfer frees a place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_frame_packer_queue #(
    parameter int SLOTS        = 128,
    parameter int SLOT_SAMPLES = 2400
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [11:0]         cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  pcmq_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pcmq_pkg::rsp_item_t rsp_item
);

    logic           cmd_push;
    logic           cmd_full;
    logic           cmd_pop;
    logic           cmd_avail;
    pcmq_pkg::cmd_t cmd_in;
    pcmq_pkg::cmd_t cmd_out;

    // request classification
    pcmq_front #(
        .SLOTS        (SLOTS),
        .SLOT_SAMPLES (SLOT_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    // command queue
    pcmq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .not_empty (cmd_avail)
    );

    // memory access and results
    pcmq_back #(
        .SLOTS        (SLOTS),
        .SLOT_SAMPLES (SLOT_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_avail),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

// ===== src/pcmq_checker.sv =====
// ----------------------------------------------------------------------------
// pcmq_checker
// Port-level checks on the result channel of the pcm frame packer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcmq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input pcmq_pkg::rsp_item_t rsp_item
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result changed");

    // a committed frame is never reported with an error
    a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.frame_committed |-> rsp_item.status == pcmq_pkg::ST_OK)
        else $error("commit with error status");

    // a commit leaves the assembly empty
    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.frame_committed |-> rsp_item.fill_level == 12'd0)
        else $error("commit left samples in assembly");

    // empty status agrees with the reported queue
    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status == pcmq_pkg::ST_EMPTY
        |-> rsp_item.queue_level == 8'd0 && rsp_item.front_length == 12'd0)
        else $error("empty status with frames queued");

    // only a successful read returns sample data
    a_sample_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.read_sample != 16'sd0 |-> rsp_item.status == pcmq_pkg::ST_OK)
        else $error("sample data with error status");

endmodule

bind pcm_frame_packer_queue pcmq_checker u_pcmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pcm_frame_packer_queue. A directed table covers the
// empty ring, sample extremes, silent samples, partial and shortened frames
// and out-of-range reads. Random traffic over changing frame lengths and a
// final ring overflow follow. Every result is compared field by field against
// a typed expectation or an in-bench model of the packer and frame ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS        = 128;
    localparam int SLOT_SAMPLES = 2400;
    localparam int RAND_ITEMS   = 320;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 200;

    // one directed step: a frame length write or a request
    typedef struct {
        bit                  is_cfg;
        logic [11:0]         cfg_val;
        pcmq_pkg::req_item_t item;
        bit                  typed;
        pcmq_pkg::rsp_item_t want;
    } dir_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [11:0]         cfg_data  = '0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    pcmq_pkg::req_item_t req_item  = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    pcmq_pkg::rsp_item_t rsp_item;

    // model of the packer and the frame ring
    logic [15:0] pk_slot_mem [SLOTS][SLOT_SAMPLES];
    int          pk_slot_len [SLOTS];
    logic [15:0] pk_asm [SLOT_SAMPLES];
    logic [7:0]  pk_wr;
    logic [7:0]  pk_rd;
    int          pk_fill;
    bit          pk_ovf;
    logic [11:0] pk_flen;

    pcmq_pkg::rsp_item_t due_results [$];
    dir_row_t            dir_tab [$];
    pcmq_pkg::rsp_item_t head_want;
    int                  mismatch_count = 0;
    bit                  req_no_gap = 1'b0;
    int                  ready_hold = 0;

    pcm_frame_packer_queue #(
        .SLOTS        (SLOTS),
        .SLOT_SAMPLES (SLOT_SAMPLES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // frames waiting in the ring
    function automatic logic [7:0] ring_level();
        logic [7:0] lvl;
        lvl = pk_wr - pk_rd;
        return lvl;
    endfunction

    // model: apply one request, return the result it gives
    function automatic pcmq_pkg::rsp_item_t frame_queue_next(input pcmq_pkg::req_item_t it);
        pcmq_pkg::rsp_item_t res;
        int                  target;
        int                  len;
        bit                  do_commit;
        logic [6:0]          slot;
        res       = '0;
        do_commit = 1'b0;
        target    = pk_flen;
        if (target < 1)
            target = 1;
        if (target > SLOT_SAMPLES)
            target = SLOT_SAMPLES;
        if (it.req_type == pcmq_pkg::REQ_PUSH || it.req_type == pcmq_pkg::REQ_FLUSH)
        begin
            if (pk_ovf)
            begin
                res.status = pcmq_pkg::ST_OVERFLOW;
            end
            else
            begin
                if (it.req_type == pcmq_pkg::REQ_PUSH)
                begin
                    if (pk_fill < SLOT_SAMPLES)
                    begin
                        pk_asm[pk_fill] = it.silent ? 16'd0 : it.sample;
                        pk_fill++;
                    end
                    do_commit = (pk_fill >= target);
                end
                else
                begin
                    do_commit = (pk_fill != 0);
                end
                // commit the assembled frame, or drop it into overflow
                if (do_commit)
                begin
                    len     = pk_fill;
                    pk_fill = 0;
                    if (ring_level() >= SLOTS)
                    begin
                        pk_ovf     = 1'b1;
                        res.status = pcmq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        slot = pk_wr[6:0];
                        for (int k = 0; k < len; k++)
                            pk_slot_mem[slot][k] = pk_asm[k];
                        pk_slot_len[slot]   = len;
                        pk_wr               = pk_wr + 8'd1;
                        res.frame_committed = 1'b1;
                    end
                end
            end
        end
        else if (ring_level() == 0)
        begin
            res.status = pcmq_pkg::ST_EMPTY;
        end
        else if (it.req_type == pcmq_pkg::REQ_READ)
        begin
            slot = pk_rd[6:0];
            if (it.read_index < pk_slot_len[slot])
                res.read_sample = pk_slot_mem[slot][it.read_index];
            else
                res.status = pcmq_pkg::ST_RANGE;
        end
        else
        begin
            pk_rd = pk_rd + 8'd1;
        end
        if (ring_level() != 0)
            res.front_length = 12'(pk_slot_len[pk_rd[6:0]]);
        res.queue_level = ring_level();
        res.fill_level  = 12'(pk_fill);
        return res;
    endfunction

    function automatic pcmq_pkg::req_item_t mk_req(input logic [1:0] kind,
                                                   input logic [15:0] smp,
                                                   input logic sil,
                                                   input logic [11:0] idx);
        pcmq_pkg::req_item_t it;
        it.req_type   = kind;
        it.sample     = smp;
        it.silent     = sil;
        it.read_index = idx;
        return it;
    endfunction

    function automatic pcmq_pkg::rsp_item_t mk_rsp(input logic [1:0] st, input logic cm,
                                                   input logic [11:0] flen,
                                                   input logic [15:0] smp,
                                                   input logic [7:0] lvl,
                                                   input logic [11:0] fill);
        pcmq_pkg::rsp_item_t r;
        r.status          = st;
        r.frame_committed = cm;
        r.front_length    = flen;
        r.read_sample     = smp;
        r.queue_level     = lvl;
        r.fill_level      = fill;
        return r;
    endfunction

    // random request with given mix; reads mostly aim inside the front frame
    function automatic pcmq_pkg::req_item_t random_request(input int push_pct,
                                                           input int flush_pct,
                                                           input int read_pct);
        logic [31:0]         rnd;
        logic [1:0]          kind;
        int                  pick;
        int                  flen;
        pcmq_pkg::req_item_t it;
        rnd  = $urandom;
        pick = $urandom_range(0, 99);
        flen = (ring_level() != 0) ? pk_slot_len[pk_rd[6:0]] : 0;
        if (pick < push_pct)
            kind = pcmq_pkg::REQ_PUSH;
        else if (pick < push_pct + flush_pct)
            kind = pcmq_pkg::REQ_FLUSH;
        else if (pick < push_pct + flush_pct + read_pct)
            kind = pcmq_pkg::REQ_READ;
        else
            kind = pcmq_pkg::REQ_POP;
        it.req_type   = kind;
        it.sample     = rnd[15:0];
        it.silent     = ($urandom_range(0, 7) == 0);
        it.read_index = ($urandom_range(0, 4) == 0) ? rnd[27:16]
                                                    : 12'($urandom_range(0, flen));
        return it;
    endfunction

    task automatic add_req(input logic [1:0] kind, input logic [15:0] smp, input logic sil,
                           input logic [11:0] idx, input bit typed,
                           input pcmq_pkg::rsp_item_t want);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_val = '0;
        row.item    = mk_req(kind, smp, sil, idx);
        row.typed   = typed;
        row.want    = want;
        dir_tab.push_back(row);
    endtask

    task automatic add_cfg(input logic [11:0] val);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.cfg_val = val;
        row.item    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        dir_tab.push_back(row);
    endtask

    // predict, then present one request and hold it until its transfer
    task automatic send_request(input pcmq_pkg::req_item_t it, input bit typed,
                                input pcmq_pkg::rsp_item_t want);
        pcmq_pkg::rsp_item_t pred;
        int                  gap;
        int                  pick;
        pred = frame_queue_next(it);
        due_results.push_back(typed ? want : pred);
        pick = $urandom_range(0, 99);
        if (req_no_gap || pick < 65)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_length(input logic [11:0] val);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pk_flen  = val;
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch %s: got 'h%0h expected 'h%0h", $realtime, what, got, exp_v);
        mismatch_count++;
    endtask

    // result side stalls: runs of ready, short and long stalls
    always @(posedge clk)
    begin : sink_pace
        int pick;
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                rsp_ready  <= 1'b1;
                ready_hold <= $urandom_range(1, 24);
            end
            else if (pick < 88)
            begin
                rsp_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
            else
            begin
                rsp_ready  <= 1'b0;
                ready_hold <= $urandom_range(6, 40);
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_results.size() == 0)
            begin
                note_mismatch("unexpected result", 64'(rsp_item), '0);
            end
            else
            begin
                head_want = due_results.pop_front();
                if (rsp_item.status !== head_want.status)
                    note_mismatch("status", 64'(rsp_item.status), 64'(head_want.status));
                if (rsp_item.frame_committed !== head_want.frame_committed)
                    note_mismatch("frame_committed", 64'(rsp_item.frame_committed),
                                  64'(head_want.frame_committed));
                if (rsp_item.front_length !== head_want.front_length)
                    note_mismatch("front_length", 64'(rsp_item.front_length),
                                  64'(head_want.front_length));
                if (rsp_item.read_sample !== head_want.read_sample)
                    note_mismatch("read_sample", 64'(rsp_item.read_sample),
                                  64'(head_want.read_sample));
                if (rsp_item.queue_level !== head_want.queue_level)
                    note_mismatch("queue_level", 64'(rsp_item.queue_level),
                                  64'(head_want.queue_level));
                if (rsp_item.fill_level !== head_want.fill_level)
                    note_mismatch("fill_level", 64'(rsp_item.fill_level),
                                  64'(head_want.fill_level));
            end
        end
    end

    // stimulus
    initial
    begin : stim
        int          n_rand;
        int          span;
        int          pick;
        logic [11:0] flen;
        logic [31:0] rnd;

        pk_wr   = '0;
        pk_rd   = '0;
        pk_fill = 0;
        pk_ovf  = 1'b0;
        pk_flen = pcmq_pkg::FRAME_LENGTH_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; empty ring, extremes, silent, partial and shortened frames, out-of-range reads
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_EMPTY, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd0));
        add_req(pcmq_pkg::REQ_POP, 16'h0000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_EMPTY, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd0));
        add_req(pcmq_pkg::REQ_FLUSH, 16'h0000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd0));
        add_req(pcmq_pkg::REQ_PUSH, 16'h7FFF, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd1));
        add_req(pcmq_pkg::REQ_PUSH, 16'h8000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd2));
        add_req(pcmq_pkg::REQ_PUSH, 16'h5A5A, 1'b1, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd3));
        add_req(pcmq_pkg::REQ_PUSH, 16'hFFFF, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd4));
        add_req(pcmq_pkg::REQ_FLUSH, 16'h0000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b1, 12'd4, 16'h0000, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd4, 16'h7FFF, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd1, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd4, 16'h8000, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd2, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd4, 16'h0000, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd3, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd4, 16'hFFFF, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd4, 1'b1,
                mk_rsp(pcmq_pkg::ST_RANGE, 1'b0, 12'd4, 16'h0000, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'hFFF, 1'b1,
                mk_rsp(pcmq_pkg::ST_RANGE, 1'b0, 12'd4, 16'h0000, 8'd1, 12'd0));
        add_req(pcmq_pkg::REQ_POP, 16'h0000, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd0));
        add_cfg(12'd0);
        add_req(pcmq_pkg::REQ_PUSH, 16'h1234, 1'b0, 12'd0, 1'b1,
                mk_rsp(pcmq_pkg::ST_OK, 1'b1, 12'd1, 16'h0000, 8'd1, 12'd0));
        add_cfg(12'd8);
        add_req(pcmq_pkg::REQ_PUSH, 16'h0001, 1'b0, 12'd0, 1'b0, '0);
        add_req(pcmq_pkg::REQ_PUSH, 16'h7FFE, 1'b0, 12'd0, 1'b0, '0);
        add_req(pcmq_pkg::REQ_PUSH, 16'hFFFE, 1'b0, 12'd0, 1'b0, '0);
        add_req(pcmq_pkg::REQ_PUSH, 16'h8001, 1'b0, 12'd0, 1'b0, '0);
        add_req(pcmq_pkg::REQ_PUSH, 16'hC3A5, 1'b1, 12'd0, 1'b0, '0);
        add_cfg(12'd2);
        add_req(pcmq_pkg::REQ_PUSH, 16'h2468, 1'b0, 12'd0, 1'b0, '0);
        add_req(pcmq_pkg::REQ_POP, 16'h0000, 1'b0, 12'd0, 1'b0, '0);
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd5, 1'b0, '0);
        add_req(pcmq_pkg::REQ_READ, 16'h0000, 1'b0, 12'd6, 1'b0, '0);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                set_frame_length(dir_tab[i].cfg_val);
            else
                send_request(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        end

        // random traffic over a series of frame lengths
        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       flen = 12'd0;
                1:       flen = 12'd1;
                2:       flen = 12'd2;
                7:       flen = 12'($urandom_range(17, 64));
                8:       flen = 12'd2400;
                9:       flen = 12'($urandom);
                default: flen = 12'($urandom_range(3, 16));
            endcase
            set_frame_length(flen);
            req_no_gap = ($urandom_range(0, 3) == 0);
            span       = $urandom_range(30, 80);
            repeat (span)
            begin
                if (ring_level() >= 120)
                    send_request(random_request(0, 0, 0), 1'b0, '0);
                else if (ring_level() > 90)
                    send_request(random_request(20, 10, 25), 1'b0, '0);
                else
                    send_request(random_request(48, 10, 25), 1'b0, '0);
                n_rand++;
            end
        end
        req_no_gap = 1'b0;

        // fill the ring, then commit into it by a flush: sticky overflow
        set_frame_length(12'd1);
        while (ring_level() < SLOTS)
        begin
            rnd = $urandom;
            send_request(mk_req(pcmq_pkg::REQ_PUSH, rnd[15:0], 1'b0, rnd[27:16]), 1'b0, '0);
        end
        set_frame_length(12'd2400);
        repeat (3)
        begin
            rnd = $urandom;
            send_request(mk_req(pcmq_pkg::REQ_PUSH, rnd[15:0], 1'b0, 12'd0), 1'b0, '0);
        end
        send_request(mk_req(pcmq_pkg::REQ_FLUSH, 16'h0, 1'b0, 12'd0), 1'b0, '0);
        set_frame_length(12'd1);
        repeat (80)
            send_request(random_request(25, 15, 30), 1'b0, '0);
        while (ring_level() != 0)
            send_request(mk_req(pcmq_pkg::REQ_POP, 16'h0, 1'b0, 12'd0), 1'b0, '0);
        send_request(mk_req(pcmq_pkg::REQ_READ, 16'h0, 1'b0, 12'd0), 1'b1,
                     mk_rsp(pcmq_pkg::ST_EMPTY, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd0));
        send_request(mk_req(pcmq_pkg::REQ_PUSH, 16'h7FFF, 1'b0, 12'd0), 1'b1,
                     mk_rsp(pcmq_pkg::ST_OVERFLOW, 1'b0, 12'd0, 16'h0000, 8'd0, 12'd0));

        wait_idle();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
